// ===== design/bbc_pkg.sv =====
// Shared types, codes and the character classifier for the bracket balance checker.
// No dependencies.
package bbc_pkg;

    // Verdict codes carried on the result word.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_MISMATCH    = 3'd1,
        ST_EMPTY_CLOSE = 3'd2,
        ST_UNCLOSED    = 3'd3,
        ST_OVERFLOW    = 3'd4
    } status_t;

    // Bracket kind as stored on the stack.
    typedef enum logic [1:0] {
        KIND_PAREN  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2
    } kind_t;

    localparam int KIND_W = 2;

    // Bracket characters.
    localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;  // (
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;  // )
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;  // [
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;  // {
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;  // }

    // Class of one input byte.
    typedef struct packed {
        logic  is_open;
        logic  is_close;
        kind_t kind;
    } char_class_t;

    // Result of one string, valid on its last word, from the stack controller to the output stage.
    typedef struct packed {
        logic    valid;
        status_t status;
    } bbc_result_t;

    function automatic char_class_t classify(input logic [7:0] ch);
        char_class_t c;
        c.is_open  = 1'b0;
        c.is_close = 1'b0;
        c.kind     = KIND_PAREN;
        case (ch)
            CH_OPEN_PAREN: begin
                c.is_open = 1'b1;
                c.kind    = KIND_PAREN;
            end
            CH_OPEN_SQUARE: begin
                c.is_open = 1'b1;
                c.kind    = KIND_SQUARE;
            end
            CH_OPEN_CURLY: begin
                c.is_open = 1'b1;
                c.kind    = KIND_CURLY;
            end
            CH_CLOSE_PAREN: begin
                c.is_close = 1'b1;
                c.kind     = KIND_PAREN;
            end
            CH_CLOSE_SQUARE: begin
                c.is_close = 1'b1;
                c.kind     = KIND_SQUARE;
            end
            CH_CLOSE_CURLY: begin
                c.is_close = 1'b1;
                c.kind     = KIND_CURLY;
            end
            default: begin
                c.is_open  = 1'b0;
                c.is_close = 1'b0;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== design/bbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; a read of the address being written returns old data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/bbc_stack_ctrl.sv =====
// Stack controller: depth and error registers around the bracket stack RAM.
// Depends on bbc_pkg and bbc_ram.
module bbc_stack_ctrl #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          char_byte,
    input  logic                is_last,
    output bbc_pkg::bbc_result_t result
);
    import bbc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [DW-1:0]     depth_reg, depth_next;
    status_t           err_reg, err_next;
    logic              bypass_reg;
    kind_t             bypass_kind_reg;
    char_class_t       cls;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [KIND_W-1:0] rd_data;
    logic [KIND_W-1:0] top_kind;
    status_t           verdict;

    // The RAM always reads the entry that will be on top next cycle.
    bbc_ram #(
        .WIDTH(KIND_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(cls.kind),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign cls = classify(char_byte);

    // A push in the previous cycle collided with its own read, so take the pushed kind.
    assign top_kind = bypass_reg ? bypass_kind_reg : rd_data;
    assign wr_addr  = depth_reg[AW-1:0];
    assign rd_addr  = (depth_next == '0) ? '0 : AW'(depth_next - DW'(1));

    // Push, pop and first-error logic for the accepted word.
    always_comb begin
        depth_next = depth_reg;
        err_next   = err_reg;
        wr_en      = 1'b0;
        verdict    = ST_OK;
        if (accept && err_reg == ST_OK) begin
            if (cls.is_open) begin
                if (depth_reg == DW'(STACK_DEPTH)) begin
                    err_next = ST_OVERFLOW;
                end else begin
                    wr_en      = 1'b1;
                    depth_next = depth_reg + DW'(1);
                end
            end else if (cls.is_close) begin
                if (depth_reg == '0) begin
                    err_next = ST_EMPTY_CLOSE;
                end else begin
                    depth_next = depth_reg - DW'(1);
                    if (top_kind != cls.kind) begin
                        err_next = ST_MISMATCH;
                    end
                end
            end
        end
        // Verdict on the last word, then the string state returns to empty.
        verdict = err_next;
        if (err_next == ST_OK && depth_next != '0) begin
            verdict = ST_UNCLOSED;
        end
        if (accept && is_last) begin
            depth_next = '0;
            err_next   = ST_OK;
        end
    end

    assign result.valid  = accept && is_last;
    assign result.status = verdict;

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg  <= '0;
            err_reg    <= ST_OK;
            bypass_reg <= 1'b0;
        end else begin
            depth_reg  <= depth_next;
            err_reg    <= err_next;
            bypass_reg <= wr_en;
        end
        bypass_kind_reg <= cls.kind;
    end

endmodule

// ===== design/bracket_balance_checker.sv =====
// Bracket balance checker: top level with the handshake and the result register.
// Depends on bbc_pkg and bbc_stack_ctrl.
// One word per cycle unless m_ stalls; the stack top is a registered RAM read with a push bypass.
// Latency: the result appears on m_ the cycle after the last word of a string is accepted.
// Reset (aresetn, sync, active low) empties the stack, clears the error and m_valid; no RAM clear.
module bracket_balance_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_byte,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_balanced,
    output logic [2:0] m_status
);
    import bbc_pkg::*;

    logic        accept;
    bbc_result_t result;
    logic        m_valid_reg, m_valid_next;
    status_t     m_status_reg, m_status_next;

    // A new word is taken whenever the result register is free or being emptied.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    bbc_stack_ctrl #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .char_byte(s_char_byte),
        .is_last  (s_is_last),
        .result   (result)
    );

    // Result register.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        if (result.valid) begin
            m_valid_next  = 1'b1;
            m_status_next = result.status;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_status_reg <= m_status_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_balanced = (m_status_reg == ST_OK);

    // A pending result that is not taken blocks new words.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while a result is stalled");

    // A last word always yields a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_is_last) |=> m_valid)
        else $error("no result after last word");

    // A word that is not last never creates a new result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && !(s_valid && s_ready && s_is_last)) |=> !m_valid)
        else $error("result without a last word");

    // Status codes stay within the defined set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_MISMATCH ||
                     m_status == ST_EMPTY_CLOSE || m_status == ST_UNCLOSED ||
                     m_status == ST_OVERFLOW))
        else $error("undefined status code");

endmodule
